FILE: hdl/tspq_pkg.sv
// Shared types, codes and defaults of the timed sorted priority queue.
package tspq_pkg;

	// Default sizes
	localparam int DEPTH_DEF     = 32;
	localparam int ID_BITS_DEF   = 16;
	localparam int TIME_BITS_DEF = 20;

	// Configuration port
	localparam int          PADDR_W      = 3;
	localparam logic        KEY_SEL_WORD = 1'b0;

	// Operation codes on the kind input
	localparam logic [1:0] KIND_ENQ = 2'd0;
	localparam logic [1:0] KIND_DEQ = 2'd1;
	localparam logic [1:0] KIND_ADV = 2'd2;

	// Result status codes
	localparam logic [2:0] STAT_OUT      = 3'd0;
	localparam logic [2:0] STAT_ENQUEUED = 3'd1;
	localparam logic [2:0] STAT_FULL     = 3'd2;
	localparam logic [2:0] STAT_EMPTY    = 3'd3;
	localparam logic [2:0] STAT_NONE_DUE = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_PUT,
		S_ADV,
		S_ADV_CHK,
		S_POP
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_REPORT,
		DP_ENQ_START,
		DP_INS_SHIFT,
		DP_INS_PUT,
		DP_DEQ_START,
		DP_ADV_START,
		DP_ADV_STEP,
		DP_POP_START,
		DP_POP
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic shift;
		logic pos_one;
		logic walk_last;
		logic due_zero;
		logic due_last;
	} dp_stat_t;

endpackage

FILE: hdl/tspq_ctrl.sv
// Sequencing state machine of the timed sorted priority queue.
module tspq_ctrl import tspq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy
);

	ctrl_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd.op    = DP_NOP;
		cmd.code  = STAT_NONE_DUE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_ENQ: begin
							if (stat.full) begin
								cmd.op   = DP_REPORT;
								cmd.code = STAT_FULL;
							end else begin
								cmd.op    = DP_ENQ_START;
								state_nxt = stat.empty ? S_INS_PUT : S_INS;
							end
						end
						KIND_DEQ: begin
							if (stat.empty) begin
								cmd.op   = DP_REPORT;
								cmd.code = STAT_EMPTY;
							end else begin
								cmd.op    = DP_DEQ_START;
								state_nxt = S_POP;
							end
						end
						KIND_ADV: begin
							if (stat.empty) begin
								cmd.op = DP_REPORT;
							end else begin
								cmd.op    = DP_ADV_START;
								state_nxt = S_ADV;
							end
						end
						default: begin
							cmd.op = DP_REPORT;
						end
					endcase
				end
			end
			S_INS: begin
				if (stat.shift) begin
					cmd.op = DP_INS_SHIFT;
					if (stat.pos_one) begin
						state_nxt = S_INS_PUT;
					end
				end else begin
					cmd.op    = DP_INS_PUT;
					state_nxt = S_IDLE;
				end
			end
			S_INS_PUT: begin
				cmd.op    = DP_INS_PUT;
				state_nxt = S_IDLE;
			end
			S_ADV: begin
				cmd.op = DP_ADV_STEP;
				if (stat.walk_last) begin
					state_nxt = S_ADV_CHK;
				end
			end
			S_ADV_CHK: begin
				if (stat.due_zero) begin
					cmd.op    = DP_REPORT;
					state_nxt = S_IDLE;
				end else begin
					cmd.op    = DP_POP_START;
					state_nxt = S_POP;
				end
			end
			S_POP: begin
				cmd.op = DP_POP;
				if (stat.due_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: hdl/tspq_dp.sv
// Datapath of the timed sorted priority queue: entry memory, pointers, result register.
module tspq_dp import tspq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic                       key_sel,
	input  logic [ID_BITS-1:0]         item_id,
	input  logic [TIME_BITS-1:0]       send_time,
	input  logic [TIME_BITS-1:0]       exp_time,
	input  logic [TIME_BITS-1:0]       step_amount,
	output dp_stat_t                   stat,
	output logic                       valid,
	output logic [2:0]                 status,
	output logic [ID_BITS-1:0]         out_item_id,
	output logic [TIME_BITS-1:0]       out_send_time,
	output logic [TIME_BITS-1:0]       out_exp_time,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic                       last
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = ID_BITS + 2 * TIME_BITS;

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] l);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, h} + {1'b0, l};
		if (sum >= (CNT_W + 1)'(DEPTH)) begin
			sum = sum - (CNT_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	logic [ENT_W-1:0]     mem_q [DEPTH];
	logic [ENT_W-1:0]     rdata_q;
	logic [IDX_W-1:0]     head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     rd_q;
	logic [CNT_W-1:0]     due_q;
	logic                 prefix_q;
	logic [ID_BITS-1:0]   id_q;
	logic [TIME_BITS-1:0] snd_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] step_q;

	logic                 we, re;
	logic [IDX_W-1:0]     waddr, raddr;
	logic [ENT_W-1:0]     wdata;

	logic [ID_BITS-1:0]   rd_id;
	logic [TIME_BITS-1:0] rd_snd, rd_exp, rd_key, new_key, sat_key;
	logic                 shift;
	logic [ENT_W-1:0]     adv_entry;

	assign rd_id   = rdata_q[ENT_W-1 -: ID_BITS];
	assign rd_snd  = rdata_q[2*TIME_BITS-1 -: TIME_BITS];
	assign rd_exp  = rdata_q[TIME_BITS-1:0];
	assign rd_key  = key_sel ? rd_snd : rd_exp;
	assign new_key = key_sel ? snd_q : exp_q;
	assign shift   = (new_key < rd_key);
	assign sat_key = (rd_key > step_q) ? (rd_key - step_q) : '0;
	assign adv_entry = key_sel ? {rd_id, sat_key, rd_exp} : {rd_id, rd_snd, sat_key};

	assign stat.full      = (count_q == CNT_W'(DEPTH));
	assign stat.empty     = (count_q == '0);
	assign stat.shift     = shift;
	assign stat.pos_one   = (pos_q == CNT_W'(1));
	assign stat.walk_last = (rd_q == count_q);
	assign stat.due_zero  = (due_q == '0);
	assign stat.due_last  = (due_q == CNT_W'(1));

	// Memory port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = head_q;
		raddr = head_q;
		wdata = rdata_q;
		case (cmd.op)
			DP_ENQ_START: begin
				re    = (count_q != '0);
				raddr = phys(head_q, count_q - CNT_W'(1));
			end
			DP_INS_SHIFT: begin
				we    = 1'b1;
				waddr = phys(head_q, pos_q);
				re    = (pos_q != CNT_W'(1));
				raddr = phys(head_q, pos_q - CNT_W'(2));
			end
			DP_INS_PUT: begin
				we    = 1'b1;
				waddr = phys(head_q, pos_q);
				wdata = {id_q, snd_q, exp_q};
			end
			DP_DEQ_START, DP_ADV_START, DP_POP_START: begin
				re = 1'b1;
			end
			DP_ADV_STEP: begin
				we    = 1'b1;
				waddr = phys(head_q, rd_q - CNT_W'(1));
				wdata = adv_entry;
				re    = (rd_q < count_q);
				raddr = phys(head_q, rd_q);
			end
			DP_POP: begin
				re    = (due_q != CNT_W'(1));
				raddr = phys(head_q, CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Captured operands
	always_ff @(posedge clk) begin
		if (cmd.op == DP_ENQ_START) begin
			id_q  <= item_id;
			snd_q <= send_time;
			exp_q <= exp_time;
		end
		if (cmd.op == DP_ADV_START) begin
			step_q <= step_amount;
		end
	end

	// Pointers, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q        <= '0;
			count_q       <= '0;
			pos_q         <= '0;
			rd_q          <= '0;
			due_q         <= '0;
			prefix_q      <= 1'b0;
			valid         <= 1'b0;
			status        <= STAT_NONE_DUE;
			out_item_id   <= '0;
			out_send_time <= '0;
			out_exp_time  <= '0;
			occupancy     <= '0;
			last          <= 1'b0;
		end else begin
			valid <= 1'b0;
			case (cmd.op)
				DP_REPORT: begin
					valid         <= 1'b1;
					status        <= cmd.code;
					out_item_id   <= '0;
					out_send_time <= '0;
					out_exp_time  <= '0;
					occupancy     <= count_q;
					last          <= 1'b1;
				end
				DP_ENQ_START: begin
					pos_q <= count_q;
				end
				DP_INS_SHIFT: begin
					pos_q <= pos_q - CNT_W'(1);
				end
				DP_INS_PUT: begin
					count_q       <= count_q + CNT_W'(1);
					valid         <= 1'b1;
					status        <= STAT_ENQUEUED;
					out_item_id   <= '0;
					out_send_time <= '0;
					out_exp_time  <= '0;
					occupancy     <= count_q + CNT_W'(1);
					last          <= 1'b1;
				end
				DP_DEQ_START: begin
					due_q <= CNT_W'(1);
				end
				DP_ADV_START: begin
					rd_q     <= CNT_W'(1);
					due_q    <= '0;
					prefix_q <= 1'b1;
				end
				DP_ADV_STEP: begin
					rd_q <= rd_q + CNT_W'(1);
					if (prefix_q && (sat_key == '0)) begin
						due_q <= due_q + CNT_W'(1);
					end else begin
						prefix_q <= 1'b0;
					end
				end
				DP_POP: begin
					valid         <= 1'b1;
					status        <= STAT_OUT;
					out_item_id   <= rd_id;
					out_send_time <= rd_snd;
					out_exp_time  <= rd_exp;
					occupancy     <= count_q - due_q;
					last          <= (due_q == CNT_W'(1));
					count_q       <= count_q - CNT_W'(1);
					due_q         <= due_q - CNT_W'(1);
					head_q        <= (count_q == CNT_W'(1)) ? '0 : phys(head_q, CNT_W'(1));
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/timed_sorted_priority_queue.sv
// Top level of the timed sorted priority queue: register port, controller and datapath.
// A rejected enqueue, an empty dequeue or an advance on an empty queue answers in the
//   cycle after start; an enqueue moves each entry with a later key up by one slot,
//   one entry per cycle through the entry memory, then writes the new entry.
// A dequeue reads and pops the head; an advance steps every key, then pops each entry due.
// Results carry one strobe cycle each and cannot be stalled; busy is high while working.
// Reset (arst_n low) empties the queue and clears key_select; no memory clearing pass.
module timed_sorted_priority_queue import tspq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [PADDR_W-1:0]         paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// command side
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 kind,
	input  logic [ID_BITS-1:0]         item_id,
	input  logic [TIME_BITS-1:0]       send_time,
	input  logic [TIME_BITS-1:0]       exp_time,
	input  logic [TIME_BITS-1:0]       step_amount,
	// result side
	output logic                       valid,
	output logic [2:0]                 status,
	output logic [ID_BITS-1:0]         out_item_id,
	output logic [TIME_BITS-1:0]       out_send_time,
	output logic [TIME_BITS-1:0]       out_exp_time,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic                       last
);

	logic     key_sel_q;
	logic     cfg_wr;
	logic     start_acc;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The register port never waits; a write lands on the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Only word 0 holds a register; writes to other words are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_sel_q <= 1'b0;
		end else if (cfg_wr && (paddr[PADDR_W-1:2] == KEY_SEL_WORD)) begin
			key_sel_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[PADDR_W-1:2] == KEY_SEL_WORD) ? {31'b0, key_sel_q} : 32'b0;

	// A transaction is taken only while the controller is idle.
	assign start_acc = start && !busy;

	tspq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_acc),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath holds the entry memory, head and count, and the result register.
	tspq_dp #(
		.DEPTH     (DEPTH),
		.ID_BITS   (ID_BITS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.key_sel       (key_sel_q),
		.item_id       (item_id),
		.send_time     (send_time),
		.exp_time      (exp_time),
		.step_amount   (step_amount),
		.stat          (stat),
		.valid         (valid),
		.status        (status),
		.out_item_id   (out_item_id),
		.out_send_time (out_send_time),
		.out_exp_time  (out_exp_time),
		.occupancy     (occupancy),
		.last          (last)
	);

endmodule

FILE: hdl/tspq_checker.sv
// Port-level checks of the timed sorted priority queue and their binding.
module tspq_checker import tspq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       busy,
	input logic                       valid,
	input logic [2:0]                 status,
	input logic [ID_BITS-1:0]         out_item_id,
	input logic [TIME_BITS-1:0]       out_send_time,
	input logic [TIME_BITS-1:0]       out_exp_time,
	input logic [$clog2(DEPTH+1)-1:0] occupancy,
	input logic                       last
);

	// A burst of removed entries comes out on consecutive cycles.
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid)
		else $error("result burst broken before its last transaction");

	// The block stays busy until the final result of a burst is out.
	a_busy_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("idle while a result burst is still running");

	// Any status other than an entry leaving is a lone, zero-payload result.
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (status != STAT_OUT) |-> last && (out_item_id == '0) &&
			(out_send_time == '0) && (out_exp_time == '0))
		else $error("status-only result with payload or without last");

	a_occupancy_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (occupancy <= ($clog2(DEPTH+1))'(DEPTH)))
		else $error("occupancy beyond queue depth");

endmodule

bind timed_sorted_priority_queue tspq_checker #(
	.DEPTH     (DEPTH),
	.ID_BITS   (ID_BITS),
	.TIME_BITS (TIME_BITS)
) u_tspq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.busy          (busy),
	.valid         (valid),
	.status        (status),
	.out_item_id   (out_item_id),
	.out_send_time (out_send_time),
	.out_exp_time  (out_exp_time),
	.occupancy     (occupancy),
	.last          (last)
);
